// File: hw/rtl/dxtb_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dxtb_pkg
// Shared types, format codes and fixed-point helpers for the DXT texel
// block decoder.
// ---------------------------------------------------------------------------
package dxtb_pkg;

  // on-disk texture format codes
  localparam logic [4:0] FMT_RGBA8888 = 5'd0;
  localparam logic [4:0] FMT_ABGR8888 = 5'd1;
  localparam logic [4:0] FMT_RGB888   = 5'd2;
  localparam logic [4:0] FMT_BGR888   = 5'd3;
  localparam logic [4:0] FMT_RGB565   = 5'd4;
  localparam logic [4:0] FMT_I8       = 5'd5;
  localparam logic [4:0] FMT_IA88     = 5'd6;
  localparam logic [4:0] FMT_A8       = 5'd8;
  localparam logic [4:0] FMT_ARGB8888 = 5'd11;
  localparam logic [4:0] FMT_BGRA8888 = 5'd12;
  localparam logic [4:0] FMT_DXT1     = 5'd13;
  localparam logic [4:0] FMT_DXT3     = 5'd14;
  localparam logic [4:0] FMT_DXT5     = 5'd15;
  localparam logic [4:0] FMT_BGRX8888 = 5'd16;
  localparam logic [4:0] FMT_BGR565   = 5'd17;
  localparam logic [4:0] FMT_DXT1_A1  = 5'd20;
  localparam logic [4:0] FMT_UV88     = 5'd22;

  localparam logic [4:0] FMT_RESET = FMT_DXT1;

  // texel positions in one block
  localparam logic [3:0] LAST_TEXEL = 4'd15;

  // how the back end has to treat an item
  typedef enum logic [2:0] {
    KIND_RAW    = 3'd0,
    KIND_RGB565 = 3'd1,
    KIND_BGR565 = 3'd2,
    KIND_DXT1   = 3'd3,
    KIND_DXT3   = 3'd4,
    KIND_DXT5   = 3'd5,
    KIND_ERROR  = 3'd6
  } kind_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  // classified item in the front-to-back queue
  typedef struct packed {
    kind_t        kind;
    logic [63:0]  color_word;
    logic [63:0]  alpha_word;
    rgba_t        raw_rgba;
  } cmd_t;

  // finished palettes handed to the texel emitter
  typedef struct packed {
    kind_t            kind;
    rgba_t [3:0]      color;
    logic [7:0][7:0]  atab;
    logic [31:0]      cidx;
    logic [63:0]      alpha_word;
    rgba_t            raw_rgba;
  } pal_t;

  // reciprocal constants: floor(x / d) == (x * M) >> S over the used range
  localparam int unsigned EXP5_MUL = 2156535; // 255 * ceil(2^18 / 31)
  localparam int unsigned EXP5_SH  = 18;
  localparam int unsigned EXP6_MUL = 4244475; // 255 * ceil(2^20 / 63)
  localparam int unsigned EXP6_SH  = 20;
  localparam int unsigned DIV3_MUL = 683;
  localparam int unsigned DIV3_SH  = 11;
  localparam int unsigned DIV7_MUL = 2341;
  localparam int unsigned DIV7_SH  = 14;
  localparam int unsigned DIV5_MUL = 1639;
  localparam int unsigned DIV5_SH  = 13;

  // v * 255 / 31
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [27:0] prod;
    prod = 28'(v) * 28'(EXP5_MUL);
    return prod[EXP5_SH +: 8];
  endfunction

  // v * 255 / 63
  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [29:0] prod;
    prod = 30'(v) * 30'(EXP6_MUL);
    return prod[EXP6_SH +: 8];
  endfunction

  // x / 3 for x <= 765
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] prod;
    prod = 21'(x) * 21'(DIV3_MUL);
    return prod[DIV3_SH +: 8];
  endfunction

  // x / 7 for x <= 1785
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] prod;
    prod = 23'(x) * 23'(DIV7_MUL);
    return prod[DIV7_SH +: 8];
  endfunction

  // x / 5 for x <= 1275
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] prod;
    prod = 23'(x) * 23'(DIV5_MUL);
    return prod[DIV5_SH +: 8];
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/dxt_texel_block_decoder.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dxt_texel_block_decoder
// DXT1/DXT3/DXT5 block and raw pixel decoder to RGBA8 texels.
// ---------------------------------------------------------------------------
// Each pushed item is one compressed 4x4 block or one raw pixel, as the
// texture_format register chooses. A block yields sixteen results in raster
// order, one per cycle on the result port while results are popped; a raw
// pixel or an unsupported format yields one result. The result port's
// one-texel-per-cycle sequencer limits how fast items go through. A
// two-entry queue sits behind the input and a two-stage palette builder
// follows it, so new items can be pushed while a block is still streaming
// out. texture_format must be written only while the decoder is idle; the
// decoder itself does not enforce this.
module dxt_texel_block_decoder (
  input  wire          clk,
  input  wire          rst,
  input  wire          cfg_wr_en,
  input  wire  [4:0]   cfg_wr_data,
  input  wire          push,
  output logic         full,
  input  wire  [63:0]  color_word,
  input  wire  [63:0]  alpha_word,
  output logic         empty,
  input  wire          pop,
  output logic [7:0]   red,
  output logic [7:0]   green,
  output logic [7:0]   blue,
  output logic [7:0]   alpha,
  output logic [3:0]   texel_index,
  output logic         last,
  output logic         format_error
);
  import dxtb_pkg::*;

  logic [4:0]  texture_format;
  logic        q_valid;
  logic        q_ready;
  cmd_t        q_cmd;
  logic        p_valid;
  logic        p_ready;
  pal_t        p_pal;

  // format register
  always_ff @(posedge clk) begin
    if (rst) begin
      texture_format <= FMT_RESET;
    end else if (cfg_wr_en) begin
      texture_format <= cfg_wr_data;
    end
  end

  // classify and queue
  dxtb_front u_front (
    .clk            (clk),
    .rst            (rst),
    .texture_format (texture_format),
    .push           (push),
    .color_word     (color_word),
    .alpha_word     (alpha_word),
    .full           (full),
    .out_valid      (q_valid),
    .out_ready      (q_ready),
    .out_cmd        (q_cmd)
  );

  // palette build
  dxtb_palette u_palette (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_cmd    (q_cmd),
    .out_valid (p_valid),
    .out_ready (p_ready),
    .out_pal   (p_pal)
  );

  // texel sequencing and result register
  dxtb_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (p_valid),
    .in_ready     (p_ready),
    .in_pal       (p_pal),
    .empty        (empty),
    .pop          (pop),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .texel_index  (texel_index),
    .last         (last),
    .format_error (format_error)
  );

  // an error result is a lone all-zero result
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && format_error) |-> (last && texel_index == 4'd0 && red == 8'd0 &&
                                  green == 8'd0 && blue == 8'd0 && alpha == 8'd0))
    else $error("error result carries data");

  // texel 15 of a block always closes it
  a_no_early_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && !last) |-> (texel_index != LAST_TEXEL))
    else $error("block texel 15 without last");

  // a non-final texel is followed by the next position
  a_texel_order: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last) |=> (empty || texel_index == $past(texel_index) + 4'd1))
    else $error("texel positions out of order");

  // nothing is shown right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result shown after reset");

endmodule
`default_nettype wire

// File: hw/rtl/dxtb_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dxtb_front
// Accepts input items, classifies them by texture format, swizzles plain
// raw pixels and queues the result in a two-entry queue for the back end.
// ---------------------------------------------------------------------------
module dxtb_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire  [4:0]           texture_format,
  input  wire                  push,
  input  wire  [63:0]          color_word,
  input  wire  [63:0]          alpha_word,
  output logic                 full,
  output logic                 out_valid,
  input  wire                  out_ready,
  output dxtb_pkg::cmd_t       out_cmd
);
  import dxtb_pkg::*;

  cmd_t        slots [2];
  cmd_t        cmd;
  logic [1:0]  count;
  logic        wr_ptr;
  logic        rd_ptr;
  logic        push_fire;
  logic        pop_fire;
  logic [7:0]  s0, s1, s2, s3;

  assign s0 = color_word[7:0];
  assign s1 = color_word[15:8];
  assign s2 = color_word[23:16];
  assign s3 = color_word[31:24];

  // classify the incoming item
  always_comb begin
    cmd.kind       = KIND_RAW;
    cmd.color_word = color_word;
    cmd.alpha_word = alpha_word;
    cmd.raw_rgba   = '0;
    unique case (texture_format) inside
      FMT_RGBA8888: cmd.raw_rgba = '{s0, s1, s2, s3};
      FMT_ABGR8888: cmd.raw_rgba = '{s3, s2, s1, s0};
      FMT_RGB888:   cmd.raw_rgba = '{s0, s1, s2, 8'hff};
      FMT_BGR888, FMT_BGRX8888:
                    cmd.raw_rgba = '{s2, s1, s0, 8'hff};
      FMT_RGB565:   cmd.kind = KIND_RGB565;
      FMT_BGR565:   cmd.kind = KIND_BGR565;
      FMT_I8:       cmd.raw_rgba = '{s0, s0, s0, 8'hff};
      FMT_IA88:     cmd.raw_rgba = '{s0, s0, s0, s1};
      FMT_A8:       cmd.raw_rgba = '{8'hff, 8'hff, 8'hff, s0};
      FMT_ARGB8888: cmd.raw_rgba = '{s1, s2, s3, s0};
      FMT_BGRA8888: cmd.raw_rgba = '{s2, s1, s0, s3};
      FMT_UV88:     cmd.raw_rgba = '{s0, s1, 8'hff, 8'hff};
      FMT_DXT1, FMT_DXT1_A1:
                    cmd.kind = KIND_DXT1;
      FMT_DXT3:     cmd.kind = KIND_DXT3;
      FMT_DXT5:     cmd.kind = KIND_DXT5;
      default:      cmd.kind = KIND_ERROR;
    endcase
  end

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_cmd   = slots[rd_ptr];
  assign push_fire = push && !full;
  assign pop_fire  = out_valid && out_ready;

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push_fire) wr_ptr <= !wr_ptr;
      if (pop_fire)  rd_ptr <= !rd_ptr;
      case ({push_fire, pop_fire})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push_fire) slots[wr_ptr] <= cmd;
  end

endmodule
`default_nettype wire

// File: hw/rtl/dxtb_palette.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dxtb_palette
// Two-stage palette builder: end color expansion and alpha weighting,
// then color and alpha interpolation into the four-entry and eight-entry
// lookup tables.
// ---------------------------------------------------------------------------
module dxtb_palette (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  dxtb_pkg::cmd_t       in_cmd,
  output logic                 out_valid,
  input  wire                  out_ready,
  output dxtb_pkg::pal_t       out_pal
);
  import dxtb_pkg::*;

  typedef struct packed {
    kind_t             kind;
    rgba_t             e0;
    rgba_t             e1;
    logic              four_color;
    logic              alpha_six;
    logic [7:0]        a0;
    logic [7:0]        a1;
    logic [5:0][10:0]  asum6;
    logic [3:0][10:0]  asum5;
    logic [31:0]       cidx;
    logic [63:0]       alpha_word;
    rgba_t             raw_rgba;
  } stage1_t;

  stage1_t  s1;
  stage1_t  s1_next;
  pal_t     pal_next;
  logic     s1_valid;
  logic     s1_ready;
  logic     s1_load;
  logic     s2_load;
  logic [15:0] c0, c1;
  logic [9:0]  sum2, sum3, sum_h;

  assign c0 = in_cmd.color_word[15:0];
  assign c1 = in_cmd.color_word[31:16];

  // stage 1: expand end colors, weight alpha end values
  always_comb begin
    s1_next.kind       = in_cmd.kind;
    s1_next.e0         = '{expand5(c0[15:11]), expand6(c0[10:5]), expand5(c0[4:0]), 8'hff};
    s1_next.e1         = '{expand5(c1[15:11]), expand6(c1[10:5]), expand5(c1[4:0]), 8'hff};
    s1_next.four_color = (in_cmd.kind != KIND_DXT1) || (c0 > c1);
    s1_next.a0         = in_cmd.alpha_word[7:0];
    s1_next.a1         = in_cmd.alpha_word[15:8];
    s1_next.alpha_six  = in_cmd.alpha_word[7:0] > in_cmd.alpha_word[15:8];
    for (int k = 1; k < 7; k++) begin
      s1_next.asum6[k-1] = 11'(7 - k) * 11'(in_cmd.alpha_word[7:0])
                         + 11'(k) * 11'(in_cmd.alpha_word[15:8]);
    end
    for (int k = 1; k < 5; k++) begin
      s1_next.asum5[k-1] = 11'(5 - k) * 11'(in_cmd.alpha_word[7:0])
                         + 11'(k) * 11'(in_cmd.alpha_word[15:8]);
    end
    s1_next.cidx       = in_cmd.color_word[63:32];
    s1_next.alpha_word = in_cmd.alpha_word;
    s1_next.raw_rgba   = in_cmd.raw_rgba;
  end

  // stage 2: interpolated palette entries and alpha table
  always_comb begin
    pal_next.kind       = s1.kind;
    pal_next.cidx       = s1.cidx;
    pal_next.alpha_word = s1.alpha_word;
    pal_next.color[0]   = s1.e0;
    pal_next.color[1]   = s1.e1;
    pal_next.color[2]   = '{8'h00, 8'h00, 8'h00, 8'hff};
    pal_next.color[3]   = '{8'h00, 8'h00, 8'h00, 8'hff};
    sum2 = '0;
    sum3 = '0;
    sum_h = '0;
    for (int ch = 0; ch < 3; ch++) begin
      logic [7:0] v0, v1;
      v0 = s1.e0[31 - 8*ch -: 8];
      v1 = s1.e1[31 - 8*ch -: 8];
      sum2 = {1'b0, v0, 1'b0} + 10'(v1);
      sum3 = 10'(v0) + {1'b0, v1, 1'b0};
      sum_h = 10'(v0) + 10'(v1);
      if (s1.four_color) begin
        pal_next.color[2][31 - 8*ch -: 8] = div3(sum2);
        pal_next.color[3][31 - 8*ch -: 8] = div3(sum3);
      end else begin
        pal_next.color[2][31 - 8*ch -: 8] = sum_h[8:1];
      end
    end
    if (!s1.four_color) pal_next.color[3].alpha = 8'h00;

    pal_next.atab[0] = s1.a0;
    pal_next.atab[1] = s1.a1;
    if (s1.alpha_six) begin
      for (int k = 0; k < 6; k++) pal_next.atab[k+2] = div7(s1.asum6[k]);
    end else begin
      for (int k = 0; k < 4; k++) pal_next.atab[k+2] = div5(s1.asum5[k]);
      pal_next.atab[6] = 8'h00;
      pal_next.atab[7] = 8'hff;
    end

    // raw 565 pixels use the first end color
    case (s1.kind)
      KIND_RGB565: pal_next.raw_rgba = s1.e0;
      KIND_BGR565: pal_next.raw_rgba = '{s1.e0.blue, s1.e0.green, s1.e0.red, 8'hff};
      default:     pal_next.raw_rgba = s1.raw_rgba;
    endcase
  end

  assign s1_ready = !s1_valid || s2_load;
  assign in_ready = s1_ready;
  assign s1_load  = in_valid && s1_ready;
  assign s2_load  = s1_valid && (!out_valid || out_ready);

  // stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (!out_valid || out_ready) out_valid <= s1_valid;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (s1_load) s1 <= s1_next;
    if (s2_load) out_pal <= pal_next;
  end

endmodule
`default_nettype wire

// File: hw/rtl/dxtb_emit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dxtb_emit
// Steps through the sixteen texels of a decoded block, or the single
// result of a raw pixel, into the result register.
// ---------------------------------------------------------------------------
module dxtb_emit (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  dxtb_pkg::pal_t       in_pal,
  output logic                 empty,
  input  wire                  pop,
  output logic [7:0]           red,
  output logic [7:0]           green,
  output logic [7:0]           blue,
  output logic [7:0]           alpha,
  output logic [3:0]           texel_index,
  output logic                 last,
  output logic                 format_error
);
  import dxtb_pkg::*;

  pal_t        cur;
  logic        cur_valid;
  logic [3:0]  cnt;
  logic        out_valid;
  logic        single;
  logic        is_last;
  logic        emit_fire;
  logic        take;
  logic [1:0]  ci;
  logic [3:0]  nib;
  logic [2:0]  ai;
  logic [5:0]  abit;
  rgba_t       texel;

  assign single = (cur.kind == KIND_RAW) || (cur.kind == KIND_RGB565) ||
                  (cur.kind == KIND_BGR565) || (cur.kind == KIND_ERROR);
  assign is_last = single || (cnt == LAST_TEXEL);

  // texel lookup for the current position
  assign ci   = cur.cidx[{cnt, 1'b0} +: 2];
  assign nib  = cur.alpha_word[{cnt, 2'b00} +: 4];
  assign abit = 6'd16 + 6'(cnt) * 6'd3;
  assign ai   = cur.alpha_word[abit +: 3];

  always_comb begin
    texel = cur.color[ci];
    case (cur.kind)
      KIND_DXT3: texel.alpha = {nib, nib};
      KIND_DXT5: texel.alpha = cur.atab[ai];
      default:   texel.alpha = cur.color[ci].alpha;
    endcase
    if (single) texel = cur.raw_rgba;
  end

  assign empty     = !out_valid;
  assign emit_fire = cur_valid && (!out_valid || pop);
  assign in_ready  = !cur_valid || (emit_fire && is_last);
  assign take      = in_valid && in_ready;

  // texel counter and valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) cur_valid <= in_valid;
      if (emit_fire) cnt <= is_last ? 4'd0 : cnt + 4'd1;
      if (emit_fire) out_valid <= 1'b1;
      else if (pop)  out_valid <= 1'b0;
    end
  end

  // current block and result register
  always_ff @(posedge clk) begin
    if (take) cur <= in_pal;
    if (emit_fire) begin
      red          <= texel.red;
      green        <= texel.green;
      blue         <= texel.blue;
      alpha        <= texel.alpha;
      texel_index  <= single ? 4'd0 : cnt;
      last         <= is_last;
      format_error <= (cur.kind == KIND_ERROR);
    end
  end

endmodule
`default_nettype wire
